[design/avg_pool_window_forward_top_assert.svh]
// Assertion helpers used by the datapath (avgp_dp).
`ifndef AVG_POOL_WINDOW_FORWARD_TOP_ASSERT_SVH
`define AVG_POOL_WINDOW_FORWARD_TOP_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define AVGP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AVGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/avgp_pkg.sv]
package avgp_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_WINDOW  = 8;
    localparam int SAMPLE_BITS = 16;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int WIN_IDX_W   = $clog2(MAX_WINDOW);
    // window sum: up to MAX_WINDOW^2 samples
    localparam int ACC_W       = SAMPLE_BITS + 2 * WIN_IDX_W;
    localparam int PROD_W      = ACC_W + 17;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EMIT = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        CFG_IN_WIDTH    = 3'd0,
        CFG_IN_HEIGHT   = 3'd1,
        CFG_WINDOW_SIZE = 3'd2,
        CFG_STEP        = 3'd3,
        CFG_PADDING     = 3'd4,
        CFG_OUT_WIDTH   = 3'd5,
        CFG_OUT_HEIGHT  = 3'd6,
        CFG_SCALE       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic load_wr;  // store the incoming pixel
        logic start;    // latch window origin, clear sum
        logic scan;     // issue one window read
        logic mul;      // scale the sum
        logic post;     // load the output register
        logic misuse;   // result is an error item
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last_cell;
        logic out_free;
    } t_sts;

endpackage

[design/avgp_ctrl.sv]
module avgp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    input  avgp_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output avgp_pkg::t_cmd  o_cmd
);
    import avgp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_POST
    } t_state;

    t_state r_state, n_state;
    logic   r_misuse, n_misuse;
    logic   accept;
    logic   is_emit;

    assign accept     = (r_state == ST_IDLE) && i_in_valid;
    assign is_emit    = (t_action'(i_action) == ACT_EMIT);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_misuse = r_misuse;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_emit && i_sts.full) begin
                        n_state  = ST_SETUP;
                        n_misuse = 1'b0;
                    end else if (is_emit || i_sts.full) begin
                        n_state  = ST_POST;
                        n_misuse = 1'b1;
                    end
                end
            end
            ST_SETUP: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.last_cell) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_MUL;
            ST_MUL:   n_state = ST_POST;
            ST_POST: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_misuse <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_misuse <= n_misuse;
        end
    end

    always_comb begin
        o_cmd.load_wr = accept && !is_emit && !i_sts.full;
        o_cmd.start   = (r_state == ST_SETUP);
        o_cmd.scan    = (r_state == ST_SCAN);
        o_cmd.mul     = (r_state == ST_MUL);
        o_cmd.post    = (r_state == ST_POST) && i_sts.out_free;
        o_cmd.misuse  = r_misuse;
    end

endmodule

[design/avgp_dp.sv]
`include "avg_pool_window_forward_top_assert.svh"

module avgp_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  avgp_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic [15:0]         i_sample,
    input  avgp_pkg::t_cmd      i_cmd,
    output avgp_pkg::t_sts      o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [15:0]         o_pooled,
    output logic                o_plane_done,
    output logic                o_misuse
);
    import avgp_pkg::*;

    // configuration
    logic [6:0]  r_in_width, r_in_height, r_out_width, r_out_height;
    logic [3:0]  r_window_size, r_step;
    logic [2:0]  r_padding;
    logic [15:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width    <= 7'd64;
            r_in_height   <= 7'd64;
            r_window_size <= 4'd2;
            r_step        <= 4'd2;
            r_padding     <= 3'd0;
            r_out_width   <= 7'd32;
            r_out_height  <= 7'd32;
            r_scale       <= 16'd16384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_WIDTH:    r_in_width    <= i_cfg_data[6:0];
                CFG_IN_HEIGHT:   r_in_height   <= i_cfg_data[6:0];
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[3:0];
                CFG_STEP:        r_step        <= i_cfg_data[3:0];
                CFG_PADDING:     r_padding     <= i_cfg_data[2:0];
                CFG_OUT_WIDTH:   r_out_width   <= i_cfg_data[6:0];
                CFG_OUT_HEIGHT:  r_out_height  <= i_cfg_data[6:0];
                CFG_SCALE:       r_scale       <= i_cfg_data;
                default:         r_scale       <= r_scale;
            endcase
        end
    end

    // effective shape after clamping
    logic [6:0]             w, h, ow, oh;
    logic [3:0]             win, st;
    logic [WIN_IDX_W-1:0]   win_m1;
    logic [CNT_W-1:0]       plane_sz;

    assign w  = (r_in_width == 7'd0) ? 7'd1 :
                (r_in_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : r_in_width;
    assign h  = (r_in_height == 7'd0) ? 7'd1 :
                (r_in_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : r_in_height;
    assign win = (r_window_size == 4'd0) ? 4'd1 :
                 (r_window_size > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : r_window_size;
    assign st = (r_step == 4'd0) ? 4'd1 : r_step;
    assign ow = (r_out_width == 7'd0) ? 7'd1 : r_out_width;
    assign oh = (r_out_height == 7'd0) ? 7'd1 : r_out_height;
    assign win_m1 = WIN_IDX_W'(win - 4'd1);
    assign plane_sz = CNT_W'({7'd0, w} * {7'd0, h});

    // plane counters
    logic [CNT_W-1:0] r_load_cnt;
    logic [6:0]       r_row, r_col;
    logic [7:0]       col_nx, row_nx;
    logic             col_wrap, row_wrap, done;

    assign col_nx   = {1'b0, r_col} + 8'd1;
    assign row_nx   = {1'b0, r_row} + 8'd1;
    assign col_wrap = (col_nx >= {1'b0, ow});
    assign row_wrap = (row_nx >= {1'b0, oh});
    assign done     = col_wrap && row_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else if (i_cmd.load_wr) begin
            r_load_cnt <= r_load_cnt + CNT_W'(1);
        end else if (i_cmd.post && !i_cmd.misuse) begin
            if (col_wrap) begin
                r_col <= '0;
                if (row_wrap) begin
                    r_row      <= '0;
                    r_load_cnt <= '0;
                end else begin
                    r_row <= row_nx[6:0];
                end
            end else begin
                r_col <= col_nx[6:0];
            end
        end
    end

    // window scan: origin, cell indexes, address
    logic signed [12:0]     r_r0, r_c0;
    logic [WIN_IDX_W-1:0]   r_n, r_m;
    logic [10:0]            row_off, col_off;
    logic signed [12:0]     row_cur, col_cur;
    logic                   in_img;
    logic [12:0]            row_base;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   last_cell;

    assign row_off   = 11'({4'd0, r_row} * {7'd0, st});
    assign col_off   = 11'({4'd0, r_col} * {7'd0, st});
    assign row_cur   = r_r0 + $signed({10'd0, r_n});
    assign col_cur   = r_c0 + $signed({10'd0, r_m});
    assign in_img    = !row_cur[12] && (row_cur[11:0] < {5'd0, h}) &&
                       !col_cur[12] && (col_cur[11:0] < {5'd0, w});
    assign row_base  = {7'd0, row_cur[5:0]} * {6'd0, w};
    assign rd_addr   = row_base[ADDR_W-1:0] + {6'd0, col_cur[5:0]};
    assign last_cell = (r_n == win_m1) && (r_m == win_m1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_r0 <= $signed({2'b00, row_off}) - $signed({10'd0, r_padding});
            r_c0 <= $signed({2'b00, col_off}) - $signed({10'd0, r_padding});
            r_n  <= '0;
            r_m  <= '0;
        end else if (i_cmd.scan) begin
            if (r_m == win_m1) begin
                r_m <= '0;
                r_n <= r_n + WIN_IDX_W'(1);
            end else begin
                r_m <= r_m + WIN_IDX_W'(1);
            end
        end
    end

    // pixel memory
    logic [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[r_load_cnt[ADDR_W-1:0]] <= i_sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan && in_img;
        end
    end

    // sum, scale, round, saturate
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W:0]   rnd;
    logic signed [PROD_W-16:0] q;
    logic [15:0]              sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc <= r_acc + ACC_W'($signed(r_rd_data));
        end
        if (i_cmd.mul) begin
            r_prod <= r_acc * $signed({1'b0, r_scale});
        end
    end

    assign rnd = {r_prod[PROD_W-1], r_prod} + (PROD_W+1)'(32768);
    assign q   = rnd[PROD_W:16];
    always_comb begin
        if (q > (PROD_W-15)'(32767)) begin
            sat = 16'h7FFF;
        end else if (q < -(PROD_W-15)'(32768)) begin
            sat = 16'h8000;
        end else begin
            sat = q[15:0];
        end
    end

    // output register
    logic        r_out_vld;
    logic [15:0] r_pooled;
    logic        r_done, r_misuse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_pooled <= i_cmd.misuse ? 16'd0 : sat;
            r_done   <= !i_cmd.misuse && done;
            r_misuse <= i_cmd.misuse;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_pooled     = r_pooled;
    assign o_plane_done = r_done;
    assign o_misuse     = r_misuse;

    always_comb begin
        o_sts.full      = (r_load_cnt >= plane_sz);
        o_sts.last_cell = last_cell;
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    `AVGP_ASSERT(a_post_room, !i_cmd.post || !r_out_vld || i_out_ready, "result overwritten")
    `AVGP_ASSERT_NEXT(a_plane_restart, i_cmd.post && !i_cmd.misuse && done, r_load_cnt == '0 && r_row == '0 && r_col == '0, "plane counters not cleared")
    `AVGP_ASSERT_NEXT(a_read_from_scan, !i_cmd.scan, !r_rd_vld, "window read without scan")

endmodule

[design/avg_pool_window_forward_top.sv]
// Zero-padded 2-D average pooling over one plane. Load items (tuser 0) write pixels in
// raster order into a 4096-entry store, one per cycle while no emit item is in progress.
// An emit item (tuser 1) reads the window one pixel per cycle through the single store
// read port, stepping through the setup, scan, drain, multiply and post states; post
// waits until the output register is free, and the next item is taken after that.
// Misuse items go from acceptance straight to post. A waiting result does not block
// further loads. The last output of a plane raises tlast and clears the plane counters.
module avg_pool_window_forward_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [15:0] sample
    input  logic                s_axis_tuser,   // [0] action
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [15:0] pooled
    output logic                m_axis_tlast,
    output logic                m_axis_tuser,   // [0] misuse
    input  logic                i_cfg_we,
    input  avgp_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import avgp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    avgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    avgp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_pooled     (m_axis_tdata),
        .o_plane_done (m_axis_tlast),
        .o_misuse     (m_axis_tuser)
    );

endmodule
